// ===== rtl/core/ps2h_pkg.sv =====
`default_nettype none

package ps2h_pkg;

    localparam int unsigned TIMER_WIDTH_DEFAULT = 16;

    localparam logic [15:0] INHIBIT_TICKS_RESET    = 16'd100;
    localparam logic [15:0] START_HOLD_TICKS_RESET = 16'd20;

    localparam int unsigned APB_ADDR_WIDTH = 3;
    localparam int unsigned APB_DATA_WIDTH = 32;

    localparam logic REG_INHIBIT_TICKS    = 1'b0;
    localparam logic REG_START_HOLD_TICKS = 1'b1;

    localparam logic [1:0] RX_STATUS_OK     = 2'd0;
    localparam logic [1:0] RX_STATUS_PARITY = 2'd1;
    localparam logic [1:0] RX_STATUS_STOP   = 2'd2;

    typedef struct packed {
        logic       clock_line;
        logic       data_line;
        logic       send_request;
        logic [7:0] send_command;
        logic [7:0] send_argument;
        logic       argument_present;
    } t_ps2h_in;

    typedef struct packed {
        logic       clock_drive_low;
        logic       data_drive_low;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [1:0] rx_status;
        logic       tx_busy;
        logic       tx_done;
    } t_ps2h_out;

    typedef struct packed {
        logic [15:0] inhibit_ticks;
        logic [15:0] start_hold_ticks;
    } t_ps2h_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/ps2_host_link_controller.sv =====
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in  (t_ps2h_in)
// output    out        o_out_valid / i_out_ready    o_out (t_ps2h_out)
// config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// Each line sample is accepted, processed and its result is registered at the
// same clock edge; one sample per cycle is sustained unless the output stalls.
// The output register is the only buffer; a new sample is taken whenever the
// output register is empty or its result is transferred in the same cycle.
// Synchronous active-low reset clears all link state and the output valid.

module ps2_host_link_controller
    import ps2h_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire t_ps2h_in                  i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output t_ps2h_out                      o_out,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0]      prdata,
    output logic                           pready
);

    t_ps2h_cfg r_cfg;
    logic      r_out_valid;
    t_ps2h_out r_out;
    t_ps2h_out w_result;
    logic      w_step;
    logic      w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_step      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inhibit_ticks    <= INHIBIT_TICKS_RESET;
            r_cfg.start_hold_ticks <= START_HOLD_TICKS_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_INHIBIT_TICKS:    r_cfg.inhibit_ticks    <= pwdata[15:0];
                REG_START_HOLD_TICKS: r_cfg.start_hold_ticks <= pwdata[15:0];
                default:              r_cfg.inhibit_ticks    <= r_cfg.inhibit_ticks;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INHIBIT_TICKS:    prdata = {16'd0, r_cfg.inhibit_ticks};
            REG_START_HOLD_TICKS: prdata = {16'd0, r_cfg.start_hold_ticks};
            default:              prdata = '0;
        endcase
    end

    ps2h_core #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (i_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/ps2h_core.sv =====
`default_nettype none

module ps2h_core
    import ps2h_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_ps2h_in  i_item,
    input  wire t_ps2h_cfg i_cfg,
    output t_ps2h_out      o_result
);

    typedef enum logic [1:0] {
        RX_START,
        RX_BITS,
        RX_PARITY,
        RX_STOP
    } t_rx_phase;

    typedef enum logic [3:0] {
        TX_IDLE,
        TX_INHIBIT,
        TX_START,
        TX_DATA,
        TX_PAR,
        TX_STOPBIT,
        TX_ACK_DATA_LOW,
        TX_ACK_CLOCK_LOW,
        TX_ACK_CLOCK_HIGH,
        TX_ACK_DATA_HIGH
    } t_tx_phase;

    logic                   r_prev_clock, n_prev_clock;
    t_rx_phase              r_rx_phase, n_rx_phase;
    logic [7:0]             r_rx_shift, n_rx_shift;
    logic [3:0]             r_rx_bits_left, n_rx_bits_left;
    logic                   r_rx_parity, n_rx_parity;
    t_tx_phase              r_tx_phase, n_tx_phase;
    logic [7:0]             r_tx_shift, n_tx_shift;
    logic [7:0]             r_pend_arg, n_pend_arg;
    logic                   r_arg_pending, n_arg_pending;
    logic [3:0]             r_tx_bit_count, n_tx_bit_count;
    logic                   r_tx_parity, n_tx_parity;
    logic [TIMER_WIDTH-1:0] r_hold_timer, n_hold_timer;
    logic                   r_clock_drive, n_clock_drive;
    logic                   r_data_drive, n_data_drive;

    logic                   w_fall;
    logic                   w_timer_done;
    logic [TIMER_WIDTH-1:0] w_inhibit_load;
    logic [TIMER_WIDTH-1:0] w_start_load;
    logic                   w_rx_valid;
    logic [7:0]             w_rx_byte;
    logic [1:0]             w_rx_status;
    logic                   w_tx_done;

    assign w_fall         = r_prev_clock && !i_item.clock_line;
    assign w_timer_done   = r_hold_timer <= TIMER_WIDTH'(1);
    assign w_inhibit_load = TIMER_WIDTH'(i_cfg.inhibit_ticks);
    assign w_start_load   = TIMER_WIDTH'(i_cfg.start_hold_ticks);

    always_comb begin
        n_prev_clock   = i_item.clock_line;
        n_rx_phase     = r_rx_phase;
        n_rx_shift     = r_rx_shift;
        n_rx_bits_left = r_rx_bits_left;
        n_rx_parity    = r_rx_parity;
        w_rx_valid     = 1'b0;
        w_rx_byte      = 8'd0;
        w_rx_status    = RX_STATUS_OK;

        if (r_tx_phase == TX_IDLE && w_fall) begin
            unique case (r_rx_phase)
                RX_START: begin
                    if (!i_item.data_line) begin
                        n_rx_bits_left = 4'd8;
                        n_rx_parity    = 1'b0;
                        n_rx_phase     = RX_BITS;
                    end
                end
                RX_BITS: begin
                    n_rx_shift     = {i_item.data_line, r_rx_shift[7:1]};
                    n_rx_parity    = r_rx_parity ^ i_item.data_line;
                    n_rx_bits_left = r_rx_bits_left - 4'd1;
                    if (n_rx_bits_left == 4'd0) begin
                        n_rx_phase = RX_PARITY;
                    end
                end
                RX_PARITY: begin
                    n_rx_parity = r_rx_parity ^ i_item.data_line;
                    if (n_rx_parity) begin
                        n_rx_phase = RX_STOP;
                    end else begin
                        w_rx_valid  = 1'b1;
                        w_rx_byte   = r_rx_shift;
                        w_rx_status = RX_STATUS_PARITY;
                        n_rx_phase  = RX_START;
                    end
                end
                RX_STOP: begin
                    w_rx_valid  = 1'b1;
                    w_rx_byte   = r_rx_shift;
                    w_rx_status = i_item.data_line ? RX_STATUS_OK : RX_STATUS_STOP;
                    n_rx_phase  = RX_START;
                end
                default: begin
                    n_rx_phase = RX_START;
                end
            endcase
        end
    end

    always_comb begin
        n_tx_phase     = r_tx_phase;
        n_tx_shift     = r_tx_shift;
        n_pend_arg     = r_pend_arg;
        n_arg_pending  = r_arg_pending;
        n_tx_bit_count = r_tx_bit_count;
        n_tx_parity    = r_tx_parity;
        n_hold_timer   = r_hold_timer;
        n_clock_drive  = r_clock_drive;
        n_data_drive   = r_data_drive;
        w_tx_done      = 1'b0;

        unique case (r_tx_phase)
            TX_IDLE: begin
                if (i_item.send_request) begin
                    n_tx_shift    = i_item.send_command;
                    n_pend_arg    = i_item.send_argument;
                    n_arg_pending = i_item.argument_present;
                    n_tx_phase    = TX_INHIBIT;
                    n_hold_timer  = w_inhibit_load;
                    n_clock_drive = 1'b1;
                    n_data_drive  = 1'b0;
                end
            end
            TX_INHIBIT: begin
                if (w_timer_done) begin
                    n_tx_phase   = TX_START;
                    n_data_drive = 1'b1;
                    n_hold_timer = w_start_load;
                end else begin
                    n_hold_timer = r_hold_timer - TIMER_WIDTH'(1);
                end
            end
            TX_START: begin
                if (w_timer_done) begin
                    n_clock_drive  = 1'b0;
                    n_tx_bit_count = 4'd0;
                    n_tx_parity    = 1'b0;
                    n_tx_phase     = TX_DATA;
                end else begin
                    n_hold_timer = r_hold_timer - TIMER_WIDTH'(1);
                end
            end
            TX_DATA: begin
                if (w_fall) begin
                    n_data_drive   = !r_tx_shift[0];
                    n_tx_parity    = r_tx_parity ^ r_tx_shift[0];
                    n_tx_shift     = {1'b0, r_tx_shift[7:1]};
                    n_tx_bit_count = r_tx_bit_count + 4'd1;
                    if (n_tx_bit_count >= 4'd8) begin
                        n_tx_phase = TX_PAR;
                    end
                end
            end
            TX_PAR: begin
                if (w_fall) begin
                    n_data_drive = r_tx_parity;
                    n_tx_phase   = TX_STOPBIT;
                end
            end
            TX_STOPBIT: begin
                if (w_fall) begin
                    n_data_drive = 1'b0;
                    n_tx_phase   = TX_ACK_DATA_LOW;
                end
            end
            TX_ACK_DATA_LOW: begin
                if (!i_item.data_line) begin
                    n_tx_phase = TX_ACK_CLOCK_LOW;
                end
            end
            TX_ACK_CLOCK_LOW: begin
                if (!i_item.clock_line) begin
                    n_tx_phase = TX_ACK_CLOCK_HIGH;
                end
            end
            TX_ACK_CLOCK_HIGH: begin
                if (i_item.clock_line) begin
                    n_tx_phase = TX_ACK_DATA_HIGH;
                end
            end
            TX_ACK_DATA_HIGH: begin
                if (i_item.data_line) begin
                    if (r_arg_pending) begin
                        n_arg_pending = 1'b0;
                        n_tx_shift    = r_pend_arg;
                        n_tx_phase    = TX_INHIBIT;
                        n_hold_timer  = w_inhibit_load;
                        n_clock_drive = 1'b1;
                        n_data_drive  = 1'b0;
                    end else begin
                        n_tx_phase = TX_IDLE;
                        w_tx_done  = 1'b1;
                    end
                end
            end
            default: begin
                n_tx_phase    = TX_IDLE;
                n_clock_drive = 1'b0;
                n_data_drive  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clock   <= 1'b1;
            r_rx_phase     <= RX_START;
            r_rx_shift     <= 8'd0;
            r_rx_bits_left <= 4'd0;
            r_rx_parity    <= 1'b0;
            r_tx_phase     <= TX_IDLE;
            r_tx_shift     <= 8'd0;
            r_pend_arg     <= 8'd0;
            r_arg_pending  <= 1'b0;
            r_tx_bit_count <= 4'd0;
            r_tx_parity    <= 1'b0;
            r_hold_timer   <= '0;
            r_clock_drive  <= 1'b0;
            r_data_drive   <= 1'b0;
        end else if (i_step) begin
            r_prev_clock   <= n_prev_clock;
            r_rx_phase     <= n_rx_phase;
            r_rx_shift     <= n_rx_shift;
            r_rx_bits_left <= n_rx_bits_left;
            r_rx_parity    <= n_rx_parity;
            r_tx_phase     <= n_tx_phase;
            r_tx_shift     <= n_tx_shift;
            r_pend_arg     <= n_pend_arg;
            r_arg_pending  <= n_arg_pending;
            r_tx_bit_count <= n_tx_bit_count;
            r_tx_parity    <= n_tx_parity;
            r_hold_timer   <= n_hold_timer;
            r_clock_drive  <= n_clock_drive;
            r_data_drive   <= n_data_drive;
        end
    end

    always_comb begin
        o_result.clock_drive_low = n_clock_drive;
        o_result.data_drive_low  = n_data_drive;
        o_result.rx_valid        = w_rx_valid;
        o_result.rx_byte         = w_rx_byte;
        o_result.rx_status       = w_rx_status;
        o_result.tx_busy         = n_tx_phase != TX_IDLE;
        o_result.tx_done         = w_tx_done;
    end

endmodule

`default_nettype wire
